// ----- hdl/gdtt_pkg.sv -----
// shared constants, status codes and month tables for the date to ticks converter
`default_nettype none

package gdtt_pkg;

  // field widths
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MSEC_W   = 10;
  localparam int TICKS_W  = 62;
  localparam int STATUS_W = 2;

  // internal widths
  localparam int DAYS_W = 22;   // day count up to 9999-12-31 stays below 2**22
  localparam int TOD_W  = 41;   // unchecked time of day stays below 2**41
  localparam int CUM_W  = 9;    // days before month, up to 335
  localparam int QUO_W  = 8;    // year / 100 for any 14-bit year
  localparam int REM_W  = 7;    // year % 100

  // reciprocal for division by 100: (x * 5243) >> 19 is exact for x below 2**14
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  // tick weights
  localparam logic [39:0] TICKS_PER_DAY  = 40'd864000000000;
  localparam logic [35:0] TICKS_PER_HOUR = 36'd36000000000;
  localparam logic [29:0] TICKS_PER_MIN  = 30'd600000000;
  localparam logic [23:0] TICKS_PER_SEC  = 24'd10000000;
  localparam logic [13:0] TICKS_PER_MS   = 14'd10000;

  // day weight split into two 20-bit halves for the product
  localparam int HALF_W = 20;
  localparam logic [HALF_W-1:0] TPD_LO = HALF_W'(TICKS_PER_DAY % (40'd1 << HALF_W));
  localparam logic [HALF_W-1:0] TPD_HI = HALF_W'(TICKS_PER_DAY >> HALF_W);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_LENGTH = 2'd2
  } status_t;

  // days before the first of the month
  function automatic logic [CUM_W-1:0] month_cum(input logic leap,
                                                 input logic [MONTH_W-1:0] mo);
    logic [CUM_W-1:0] base;
    base = '0;
    case (mo)
      4'd1:  base = 9'd0;
      4'd2:  base = 9'd31;
      4'd3:  base = 9'd59;
      4'd4:  base = 9'd90;
      4'd5:  base = 9'd120;
      4'd6:  base = 9'd151;
      4'd7:  base = 9'd181;
      4'd8:  base = 9'd212;
      4'd9:  base = 9'd243;
      4'd10: base = 9'd273;
      4'd11: base = 9'd304;
      4'd12: base = 9'd334;
      default: base = 9'd0;
    endcase
    // leap day counts from march on
    if (leap && mo > 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // length of the month
  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] mo);
    logic [DAY_W-1:0] len;
    len = '0;
    case (mo)
      4'd2:  len = leap ? 5'd29 : 5'd28;
      4'd4:  len = 5'd30;
      4'd6:  len = 5'd30;
      4'd9:  len = 5'd30;
      4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/gregorian_date_to_ticks_unit.sv -----
// date and time of day to 100 ns ticks, four-stage pipeline
// throughput: one word per cycle, limited by the output register's handshake only
// each stage holds its word while the next is full and cannot move on; bubbles are filled as words move up
// reset clears every stage's valid bit; payload registers are not reset
`default_nettype none

module gregorian_date_to_ticks_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output      logic                              req_ready,
  input  wire logic [gdtt_pkg::YEAR_W-1:0]       year,
  input  wire logic [gdtt_pkg::MONTH_W-1:0]      month,
  input  wire logic [gdtt_pkg::DAY_W-1:0]        day,
  input  wire logic [gdtt_pkg::HOUR_W-1:0]       hour,
  input  wire logic [gdtt_pkg::MINUTE_W-1:0]     minute,
  input  wire logic [gdtt_pkg::SECOND_W-1:0]     second,
  input  wire logic [gdtt_pkg::MSEC_W-1:0]       millisecond,
  output      logic                              rsp_valid,
  input  wire logic                              rsp_ready,
  output      logic [gdtt_pkg::TICKS_W-1:0]      ticks,
  output      logic [gdtt_pkg::STATUS_W-1:0]     status
);

  // stage valid bits and per-stage load enables
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || rsp_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign req_ready = rdy1;

  // stage 1: range check, reciprocal products, time-of-day products
  logic [gdtt_pkg::YEAR_W-1:0]  y_in;
  logic                         range_err_next;

  logic [gdtt_pkg::YEAR_W-1:0]  s1_year;
  logic [gdtt_pkg::MONTH_W-1:0] s1_month;
  logic [gdtt_pkg::DAY_W-1:0]   s1_day;
  logic [gdtt_pkg::PROD_W-1:0]  s1_qy_prod;
  logic [gdtt_pkg::PROD_W-1:0]  s1_qyr_prod;
  logic                         s1_range_err;
  logic [gdtt_pkg::TOD_W-1:0]   s1_hr_t, s1_mi_t, s1_se_t, s1_ms_t;

  assign y_in = year - gdtt_pkg::YEAR_W'(1);
  assign range_err_next = (year == '0) || (year > gdtt_pkg::YEAR_MAX) ||
                          (month == '0) || (month > gdtt_pkg::MONTH_MAX) ||
                          (day == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= req_valid;
    end
    if (rdy1) begin
      s1_year      <= year;
      s1_month     <= month;
      s1_day       <= day;
      s1_qy_prod   <= gdtt_pkg::PROD_W'(y_in) * gdtt_pkg::PROD_W'(gdtt_pkg::RECIP_100);
      s1_qyr_prod  <= gdtt_pkg::PROD_W'(year) * gdtt_pkg::PROD_W'(gdtt_pkg::RECIP_100);
      s1_range_err <= range_err_next;
      s1_hr_t <= gdtt_pkg::TOD_W'(hour) * gdtt_pkg::TOD_W'(gdtt_pkg::TICKS_PER_HOUR);
      s1_mi_t <= gdtt_pkg::TOD_W'(minute) * gdtt_pkg::TOD_W'(gdtt_pkg::TICKS_PER_MIN);
      s1_se_t <= gdtt_pkg::TOD_W'(second) * gdtt_pkg::TOD_W'(gdtt_pkg::TICKS_PER_SEC);
      s1_ms_t <= gdtt_pkg::TOD_W'(millisecond) * gdtt_pkg::TOD_W'(gdtt_pkg::TICKS_PER_MS);
    end
  end

  // stage 2: leap rule, month length check, day count, time-of-day sum
  logic [gdtt_pkg::QUO_W-1:0]   qy, qyr;
  logic [gdtt_pkg::YEAR_W-1:0]  rem_full;
  logic [gdtt_pkg::REM_W-1:0]   rem_yr;
  logic                         leap;
  logic [gdtt_pkg::YEAR_W-1:0]  y2;
  logic [gdtt_pkg::CUM_W-1:0]   cum;
  logic [gdtt_pkg::DAY_W-1:0]   mlen;
  logic [gdtt_pkg::DAYS_W-1:0]  days_next;
  gdtt_pkg::status_t            status_next;

  logic [gdtt_pkg::DAYS_W-1:0]  s2_days;
  logic [gdtt_pkg::TOD_W-1:0]   s2_tod;
  gdtt_pkg::status_t            s2_status;

  always_comb begin
    qy       = s1_qy_prod[gdtt_pkg::RECIP_SHIFT +: gdtt_pkg::QUO_W];
    qyr      = s1_qyr_prod[gdtt_pkg::RECIP_SHIFT +: gdtt_pkg::QUO_W];
    rem_full = s1_year - gdtt_pkg::YEAR_W'(gdtt_pkg::YEAR_W'(qyr) * gdtt_pkg::YEAR_W'(100));
    rem_yr   = rem_full[gdtt_pkg::REM_W-1:0];
    // divisible by 4, and not a century unless the century divides by 4
    leap     = (s1_year[1:0] == 2'd0) && ((rem_yr != '0) || (qyr[1:0] == 2'd0));
    y2       = s1_year - gdtt_pkg::YEAR_W'(1);
    cum      = gdtt_pkg::month_cum(leap, s1_month);
    mlen     = gdtt_pkg::month_len(leap, s1_month);
    days_next = gdtt_pkg::DAYS_W'(y2) * gdtt_pkg::DAYS_W'(365)
              + gdtt_pkg::DAYS_W'(y2[gdtt_pkg::YEAR_W-1:2])
              - gdtt_pkg::DAYS_W'(qy)
              + gdtt_pkg::DAYS_W'(qy[gdtt_pkg::QUO_W-1:2])
              + gdtt_pkg::DAYS_W'(cum)
              + gdtt_pkg::DAYS_W'(s1_day)
              - gdtt_pkg::DAYS_W'(1);
    if (s1_range_err) begin
      status_next = gdtt_pkg::STATUS_RANGE;
    end else if (s1_day > mlen) begin
      status_next = gdtt_pkg::STATUS_LENGTH;
    end else begin
      status_next = gdtt_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      s2_days   <= days_next;
      s2_tod    <= s1_hr_t + s1_mi_t + s1_se_t + s1_ms_t;
      s2_status <= status_next;
    end
  end

  // stage 3: day count times ticks per day, as two half products
  localparam int PP_W = gdtt_pkg::DAYS_W + gdtt_pkg::HALF_W;

  logic [PP_W-1:0]              s3_p_lo, s3_p_hi;
  logic [gdtt_pkg::TOD_W-1:0]   s3_tod;
  gdtt_pkg::status_t            s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      s3_p_lo   <= PP_W'(s2_days) * PP_W'(gdtt_pkg::TPD_LO);
      s3_p_hi   <= PP_W'(s2_days) * PP_W'(gdtt_pkg::TPD_HI);
      s3_tod    <= s2_tod;
      s3_status <= s2_status;
    end
  end

  // stage 4: combine halves, add time of day, zero on error
  logic [gdtt_pkg::TICKS_W-1:0] ticks_next;
  gdtt_pkg::status_t            s4_status;

  always_comb begin
    ticks_next = (gdtt_pkg::TICKS_W'(s3_p_hi) << gdtt_pkg::HALF_W)
               + gdtt_pkg::TICKS_W'(s3_p_lo)
               + gdtt_pkg::TICKS_W'(s3_tod);
    if (s3_status != gdtt_pkg::STATUS_OK) begin
      ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      ticks     <= ticks_next;
      s4_status <= s3_status;
    end
  end

  assign rsp_valid = v4;
  assign status    = s4_status;

  // a flagged word never carries a tick count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != gdtt_pkg::STATUS_OK) |-> ticks == '0)
    else $error("error word with non-zero ticks");

  // status stays within the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == gdtt_pkg::STATUS_OK) || (status == gdtt_pkg::STATUS_RANGE) ||
                  (status == gdtt_pkg::STATUS_LENGTH))
    else $error("undefined status code");

  // input is held off only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> v1 && v2 && v3 && v4 && !rsp_ready)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

// ----- verif/tb_gregorian_date_to_ticks_unit.sv -----
// testbench for the date to ticks converter: tick predictor, result ledger and port drivers
`timescale 1ns / 100ps

// one expected result word
typedef struct {
  logic [gdtt_pkg::TICKS_W-1:0] ticks;
  gdtt_pkg::status_t            status;
} tick_word_t;

// gregorian leap rule
function automatic bit is_leap_year(input int unsigned yr);
  return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
endfunction

// days before the first of month idx + 1, idx 0 to 12
function automatic int unsigned cum_days(input bit leap, input int unsigned idx);
  int unsigned common_run [0:12];
  int unsigned leap_run [0:12];
  common_run = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
  leap_run   = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};
  return leap ? leap_run[idx] : common_run[idx];
endfunction

class date_tick_checker;
  localparam int unsigned YEAR_LAST  = 9999;
  localparam int unsigned MONTH_LAST = 12;
  localparam logic [63:0] T_MS   = 64'd10000;
  localparam logic [63:0] T_SEC  = 64'd1000 * T_MS;
  localparam logic [63:0] T_MIN  = 64'd60 * T_SEC;
  localparam logic [63:0] T_HOUR = 64'd60 * T_MIN;
  localparam logic [63:0] T_DAY  = 64'd24 * T_HOUR;

  tick_word_t  expected_q[$];
  int unsigned fault_count;

  function new();
    fault_count = 0;
  endfunction

  // one line per mismatch
  task report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endtask

  // expected ticks and status for one date
  function tick_word_t date_to_ticks(input logic [gdtt_pkg::YEAR_W-1:0]   yr,
                                     input logic [gdtt_pkg::MONTH_W-1:0]  mo,
                                     input logic [gdtt_pkg::DAY_W-1:0]    dy,
                                     input logic [gdtt_pkg::HOUR_W-1:0]   hr,
                                     input logic [gdtt_pkg::MINUTE_W-1:0] mi,
                                     input logic [gdtt_pkg::SECOND_W-1:0] se,
                                     input logic [gdtt_pkg::MSEC_W-1:0]   ms);
    tick_word_t  w;
    bit          leap;
    int unsigned yp;
    logic [63:0] days;
    logic [63:0] sum;
    w.ticks  = '0;
    w.status = gdtt_pkg::STATUS_RANGE;
    // component range check comes first
    if (yr < 1 || yr > YEAR_LAST || mo < 1 || mo > MONTH_LAST || dy < 1) begin
      return w;
    end
    leap = is_leap_year(yr);
    if (dy > cum_days(leap, mo) - cum_days(leap, mo - 1)) begin
      w.status = gdtt_pkg::STATUS_LENGTH;
      return w;
    end
    yp   = yr - 1;
    days = 64'(yp) * 64'd365 + 64'(yp / 4) - 64'(yp / 100) + 64'(yp / 400)
         + 64'(cum_days(leap, mo - 1)) + 64'(dy) - 64'd1;
    // time of day goes in with full weight, unchecked
    sum  = days * T_DAY + 64'(hr) * T_HOUR + 64'(mi) * T_MIN + 64'(se) * T_SEC
         + 64'(ms) * T_MS;
    w.ticks  = sum[gdtt_pkg::TICKS_W-1:0];
    w.status = gdtt_pkg::STATUS_OK;
    return w;
  endfunction

  function void note_date(input logic [gdtt_pkg::YEAR_W-1:0]   yr,
                          input logic [gdtt_pkg::MONTH_W-1:0]  mo,
                          input logic [gdtt_pkg::DAY_W-1:0]    dy,
                          input logic [gdtt_pkg::HOUR_W-1:0]   hr,
                          input logic [gdtt_pkg::MINUTE_W-1:0] mi,
                          input logic [gdtt_pkg::SECOND_W-1:0] se,
                          input logic [gdtt_pkg::MSEC_W-1:0]   ms);
    expected_q.push_back(date_to_ticks(yr, mo, dy, hr, mi, se, ms));
  endfunction

  task check_result(input logic [gdtt_pkg::TICKS_W-1:0]  got_ticks,
                    input logic [gdtt_pkg::STATUS_W-1:0] got_status);
    tick_word_t exp_w;
    if (expected_q.size() == 0) begin
      report($sformatf("result word with no date pending, ticks %0d status %0d",
                       got_ticks, got_status));
    end else begin
      exp_w = expected_q.pop_front();
      if (got_ticks !== exp_w.ticks) begin
        report($sformatf("ticks %0d, expected %0d", got_ticks, exp_w.ticks));
      end
      if (got_status !== exp_w.status) begin
        report($sformatf("status %0d, expected %0d", got_status, exp_w.status));
      end
    end
  endtask

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_gregorian_date_to_ticks_unit;

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_ready;
  logic [gdtt_pkg::YEAR_W-1:0]   year;
  logic [gdtt_pkg::MONTH_W-1:0]  month;
  logic [gdtt_pkg::DAY_W-1:0]    day;
  logic [gdtt_pkg::HOUR_W-1:0]   hour;
  logic [gdtt_pkg::MINUTE_W-1:0] minute;
  logic [gdtt_pkg::SECOND_W-1:0] second;
  logic [gdtt_pkg::MSEC_W-1:0]   millisecond;
  logic                          rsp_valid;
  logic                          rsp_ready;
  logic [gdtt_pkg::TICKS_W-1:0]  ticks;
  logic [gdtt_pkg::STATUS_W-1:0] status;

  date_tick_checker tick_ledger = new();
  bit               steady_feed;

  gregorian_date_to_ticks_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .millisecond (millisecond),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .ticks       (ticks),
    .status      (status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sink side: ready stretches and stalls
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    rsp_ready = 1'b0;
    forever begin
      run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 8);
      stall_len = pick_gap();
      @(negedge clk);
      rsp_ready <= 1'b1;
      repeat (run_len - 1) @(negedge clk);
      if (stall_len > 0) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        tick_ledger.note_date(year, month, day, hour, minute, second, millisecond);
      end
      if (rsp_valid && rsp_ready) begin
        tick_ledger.check_result(ticks, status);
      end
    end
  end

  // optional gap, then one date word held until accepted
  task automatic push_date(input logic [gdtt_pkg::YEAR_W-1:0]   yr,
                           input logic [gdtt_pkg::MONTH_W-1:0]  mo,
                           input logic [gdtt_pkg::DAY_W-1:0]    dy,
                           input logic [gdtt_pkg::HOUR_W-1:0]   hr,
                           input logic [gdtt_pkg::MINUTE_W-1:0] mi,
                           input logic [gdtt_pkg::SECOND_W-1:0] se,
                           input logic [gdtt_pkg::MSEC_W-1:0]   ms);
    int unsigned gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid   <= 1'b1;
    year        <= yr;
    month       <= mo;
    day         <= dy;
    hour        <= hr;
    minute      <= mi;
    second      <= se;
    millisecond <= ms;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tick_ledger.pending() != 0) @(posedge clk);
  endtask

  // random date: mostly well formed, some length errors and some full-width noise
  task automatic random_date();
    logic [gdtt_pkg::YEAR_W-1:0]   yr;
    logic [gdtt_pkg::MONTH_W-1:0]  mo;
    logic [gdtt_pkg::DAY_W-1:0]    dy;
    logic [gdtt_pkg::HOUR_W-1:0]   hr;
    logic [gdtt_pkg::MINUTE_W-1:0] mi;
    logic [gdtt_pkg::SECOND_W-1:0] se;
    logic [gdtt_pkg::MSEC_W-1:0]   ms;
    int unsigned                   pick;
    int unsigned                   len;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      yr = gdtt_pkg::YEAR_W'($urandom);
      mo = gdtt_pkg::MONTH_W'($urandom);
      dy = gdtt_pkg::DAY_W'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: yr = gdtt_pkg::YEAR_W'($urandom_range(1, 9999));
        1: yr = gdtt_pkg::YEAR_W'(400 * $urandom_range(1, 24));
        2: yr = gdtt_pkg::YEAR_W'(100 * $urandom_range(1, 99));
        3: yr = gdtt_pkg::YEAR_W'(4 * $urandom_range(1, 2499));
        default: yr = $urandom_range(0, 1) ? gdtt_pkg::YEAR_W'($urandom_range(1, 8))
                                           : gdtt_pkg::YEAR_W'($urandom_range(9992, 9999));
      endcase
      mo  = gdtt_pkg::MONTH_W'($urandom_range(1, 12));
      len = cum_days(is_leap_year(yr), mo) - cum_days(is_leap_year(yr), mo - 1);
      if (pick < 20) begin
        // past the month end, or day 31 in a 31-day month
        dy = (len < 31) ? gdtt_pkg::DAY_W'($urandom_range(len + 1, 31))
                        : gdtt_pkg::DAY_W'(31);
      end else if (pick < 32) begin
        dy = gdtt_pkg::DAY_W'(len);
      end else begin
        dy = gdtt_pkg::DAY_W'($urandom_range(1, len));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      hr = gdtt_pkg::HOUR_W'($urandom);
      mi = gdtt_pkg::MINUTE_W'($urandom);
      se = gdtt_pkg::SECOND_W'($urandom);
      ms = gdtt_pkg::MSEC_W'($urandom);
    end else begin
      hr = gdtt_pkg::HOUR_W'($urandom_range(0, 23));
      mi = gdtt_pkg::MINUTE_W'($urandom_range(0, 59));
      se = gdtt_pkg::SECOND_W'($urandom_range(0, 59));
      ms = gdtt_pkg::MSEC_W'($urandom_range(0, 999));
    end
    push_date(yr, mo, dy, hr, mi, se, ms);
  endtask

  // main sequence
  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    year        = '0;
    month       = '0;
    day         = '0;
    hour        = '0;
    minute      = '0;
    second      = '0;
    millisecond = '0;
    steady_feed = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first and last valid instants
    push_date(14'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999);
    // unchecked time of day at full width
    push_date(14'd9999, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023);
    push_date(14'd1, 4'd1, 5'd1, 5'd31, 6'd63, 6'd63, 10'd1023);
    // component out of range
    push_date(14'd0, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30, 10'd500);
    push_date(14'd10000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023);
    push_date(14'd2024, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3, 10'd4);
    push_date(14'd2024, 4'd13, 5'd31, 5'd1, 6'd2, 6'd3, 10'd4);
    push_date(14'd2024, 4'd15, 5'd1, 5'd1, 6'd2, 6'd3, 10'd4);
    push_date(14'd2024, 4'd3, 5'd0, 5'd1, 6'd2, 6'd3, 10'd4);
    push_date(14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    // range check wins over month length
    push_date(14'd0, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);
    // day past month end
    push_date(14'd2023, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd2000, 4'd2, 5'd30, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd2021, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd2021, 4'd11, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);
    // leap days that are allowed, and other valid dates in and around leap years
    push_date(14'd2024, 4'd2, 5'd29, 5'd10, 6'd20, 6'd30, 10'd40);
    push_date(14'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 10'd999);
    push_date(14'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(14'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999);
    push_date(14'd400, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 10'd1);
    drain_results();

    // random dates, with spells of back-to-back words
    for (int n = 0; n < 1800; n++) begin
      steady_feed = ((n / 150) % 3 == 1);
      if (n == 900) begin
        drain_results();
      end
      random_date();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (tick_ledger.fault_count == 0 && tick_ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/gdtt_pkg.sv
hdl/gregorian_date_to_ticks_unit.sv
verif/tb_gregorian_date_to_ticks_unit.sv
